// ----- sv/jsu_pkg.sv -----
// Shared types and codes for the JSON string unescaper.
package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_UNFINISHED     = 4'd0;
    localparam logic [3:0] ERR_UNFINISHED_HEX = 4'd1;
    localparam logic [3:0] ERR_BAD_HEX        = 4'd2;
    localparam logic [3:0] ERR_BAD_ESCAPE     = 4'd3;
    localparam logic [3:0] ERR_CONTROL        = 4'd4;
    localparam logic [3:0] ERR_STRAY_CONT     = 4'd5;
    localparam logic [3:0] ERR_LONG_LEAD      = 4'd6;
    localparam logic [3:0] ERR_TRUNC_UTF8     = 4'd7;
    localparam logic [3:0] ERR_BAD_CONT       = 4'd8;

    localparam int MAX_BYTES = 6;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [7:0]  header_byte;
        logic [31:0] string_length;
        logic [3:0]  error_code;
        logic        last_of_run;
    } out_item_t;

    // All results caused by one input beat: data bytes first, then an
    // optional finish or error record.
    typedef struct packed {
        logic [2:0]                  n_data;
        logic [MAX_BYTES-1:0][7:0]   bytes;
        logic                        tail_valid;
        logic [1:0]                  tail_kind;
        logic [7:0]                  tail_header;
        logic [31:0]                 tail_length;
        logic [3:0]                  tail_err;
    } burst_t;

endpackage

// ----- sv/json_string_unescaper_unit.sv -----
// Top level of the JSON string unescaper.
//
// Input channel (byte_*): one raw byte of a JSON string body per beat,
// starting after the opening quote; end_of_input set means no byte, the
// input has ended. Output channel (res_*): decoded data bytes, a finish
// record (length and header byte) at the closing quote, or an error record.
// The final result of each input beat carries last_of_run.
// A taken beat's results pass through the burst and output registers to
// res_*. Throughput: one input beat per cycle while each beat gives at most
// one result and res_stall is low; a beat giving k results (up to 6, e.g.
// a flushed high surrogate followed by a 3-byte code point) holds
// byte_stall while the single output register drains one beat a cycle
// unless stalled. Beats giving no result (backslash, inner hex digit) leave
// byte_stall low. A stalled receiver freezes res_*; the next input beat
// is still taken while the last result waits. Reset returns the decoder
// to plain text with no string in progress and empties both registers.
module json_string_unescaper_unit
    import jsu_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_beat,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res_beat
);

    logic   take;
    logic   busy;
    burst_t burst;

    // beat taken when the emitter can accept a fresh burst
    assign byte_stall = busy;
    assign take       = byte_valid && !busy;

    jsu_decode #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (byte_beat),
        .burst (burst)
    );

    jsu_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .burst     (burst),
        .busy      (busy),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat)
    );

endmodule

// ----- sv/jsu_decode.sv -----
// Decode state and per-beat result generation for the string unescaper.
module jsu_decode
    import jsu_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_item_t item,
    output burst_t   burst
);

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESCAPE,
        MODE_HEX,
        MODE_UTF8
    } mode_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    mode_t                  mode_reg, mode_next;
    logic [11:0]            acc_reg, acc_next;
    logic [1:0]             digits_reg, digits_next;
    logic [1:0]             follow_reg, follow_next;
    logic                   held_valid_reg, held_valid_next;
    logic [9:0]             held_reg, held_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;

    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b0, b[3:0]};
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            r = {1'b0, b[3:0] + 4'd9};
        return r;
    endfunction

    logic                   fl_need;
    logic                   hold_new;
    logic [3:0][7:0]        mb;
    logic [2:0]             mn;
    logic [2:0]             nd;
    logic                   fin;
    logic                   err;
    logic [3:0]             err_code;
    logic [4:0]             hv;
    logic [15:0]            v;
    logic [20:0]            cp;
    logic [7:0]             b;
    logic [LENGTH_BITS:0]   sum;
    logic [LENGTH_BITS-1:0] cnt_sat;
    logic [31:0]            len32;

    always_comb
    begin
        mode_next       = mode_reg;
        acc_next        = acc_reg;
        digits_next     = digits_reg;
        follow_next     = follow_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        fl_need         = 1'b0;
        hold_new        = 1'b0;
        mb              = '0;
        mn              = 3'd0;
        fin             = 1'b0;
        err             = 1'b0;
        err_code        = ERR_UNFINISHED;
        b               = item.in_byte;
        hv              = hex_val(b);
        v               = {acc_reg, hv[3:0]};
        cp              = 21'h10000 + {1'b0, held_reg, v[9:0]};

        if (item.end_of_input)
        begin
            err = 1'b1;
            if (mode_reg == MODE_HEX)
                err_code = ERR_UNFINISHED_HEX;
            else if (mode_reg == MODE_UTF8)
                err_code = ERR_TRUNC_UTF8;
        end
        else
        begin
            unique case (mode_reg)
                MODE_UTF8:
                begin
                    if (b[7:6] != 2'b10)
                    begin
                        err      = 1'b1;
                        err_code = ERR_BAD_CONT;
                    end
                    else
                    begin
                        mb[0]       = b;
                        mn          = 3'd1;
                        follow_next = follow_reg - 2'd1;
                        if (follow_reg == 2'd1)
                            mode_next = MODE_NORMAL;
                    end
                end
                MODE_HEX:
                begin
                    if (hv[4])
                    begin
                        err      = 1'b1;
                        err_code = ERR_BAD_HEX;
                    end
                    else if (digits_reg != 2'd3)
                    begin
                        acc_next    = {acc_reg[7:0], hv[3:0]};
                        digits_next = digits_reg + 2'd1;
                    end
                    else
                    begin
                        acc_next    = '0;
                        digits_next = 2'd0;
                        mode_next   = MODE_NORMAL;
                        if (v[15:7] == '0)
                        begin
                            fl_need = 1'b1;
                            mb[0]   = v[7:0];
                            mn      = 3'd1;
                        end
                        else if (v[15:11] == '0)
                        begin
                            fl_need = 1'b1;
                            mb[0]   = {3'b110, v[10:6]};
                            mb[1]   = {2'b10, v[5:0]};
                            mn      = 3'd2;
                        end
                        else if (v[15:10] == 6'b110111 && held_valid_reg)
                        begin
                            // surrogate pair joins into one 4-byte code point
                            held_valid_next = 1'b0;
                            mb[0] = {5'b11110, cp[20:18]};
                            mb[1] = {2'b10, cp[17:12]};
                            mb[2] = {2'b10, cp[11:6]};
                            mb[3] = {2'b10, cp[5:0]};
                            mn    = 3'd4;
                        end
                        else if (v[15:10] == 6'b110110)
                        begin
                            fl_need   = 1'b1;
                            hold_new  = 1'b1;
                            held_next = v[9:0];
                        end
                        else
                        begin
                            fl_need = 1'b1;
                            mb[0]   = {4'b1110, v[15:12]};
                            mb[1]   = {2'b10, v[11:6]};
                            mb[2]   = {2'b10, v[5:0]};
                            mn      = 3'd3;
                        end
                    end
                end
                MODE_ESCAPE:
                begin
                    mode_next = MODE_NORMAL;
                    fl_need   = 1'b1;
                    mn        = 3'd1;
                    unique case (b)
                        CH_QUOTE, CH_SLASH, CH_BSL: mb[0] = b;
                        CH_B: mb[0] = 8'h08;
                        CH_F: mb[0] = 8'h0c;
                        CH_N: mb[0] = 8'h0a;
                        CH_R: mb[0] = 8'h0d;
                        CH_T: mb[0] = 8'h09;
                        CH_U:
                        begin
                            mode_next   = MODE_HEX;
                            acc_next    = '0;
                            digits_next = 2'd0;
                            fl_need     = 1'b0;
                            mn          = 3'd0;
                        end
                        default:
                        begin
                            err      = 1'b1;
                            err_code = ERR_BAD_ESCAPE;
                            fl_need  = 1'b0;
                            mn       = 3'd0;
                        end
                    endcase
                end
                default:
                begin
                    if (b == CH_QUOTE)
                    begin
                        fl_need = 1'b1;
                        fin     = 1'b1;
                    end
                    else if (b == CH_BSL)
                        mode_next = MODE_ESCAPE;
                    else if (!b[7])
                    begin
                        if (b < 8'h20)
                        begin
                            err      = 1'b1;
                            err_code = ERR_CONTROL;
                        end
                        else
                        begin
                            fl_need = 1'b1;
                            mb[0]   = b;
                            mn      = 3'd1;
                        end
                    end
                    else if (b[7:6] == 2'b10)
                    begin
                        err      = 1'b1;
                        err_code = ERR_STRAY_CONT;
                    end
                    else if (b[7:3] == 5'b11111)
                    begin
                        err      = 1'b1;
                        err_code = ERR_LONG_LEAD;
                    end
                    else
                    begin
                        // UTF-8 lead byte: 110, 1110 or 11110
                        if (b[5] == 1'b0)
                            follow_next = 2'd1;
                        else if (b[4] == 1'b0)
                            follow_next = 2'd2;
                        else
                            follow_next = 2'd3;
                        mode_next = MODE_UTF8;
                        fl_need   = 1'b1;
                        mb[0]     = b;
                        mn        = 3'd1;
                    end
                end
            endcase
        end

        // a completed element empties the hold, unless it is a new high surrogate
        if (fl_need)
            held_valid_next = hold_new;

        // flushing the held surrogate: its 3-byte form goes first
        if (fl_need && held_valid_reg)
            nd = mn + 3'd3;
        else
            nd = mn;
    end

    // Flush happens when fl_need is set and a surrogate was held before.
    logic flushed;
    assign flushed = fl_need && held_valid_reg;

    always_comb
    begin
        burst = '0;
        if (flushed)
        begin
            burst.bytes[0] = 8'hed;
            burst.bytes[1] = {4'b1010, held_reg[9:6]};
            burst.bytes[2] = {2'b10, held_reg[5:0]};
            burst.bytes[3] = mb[0];
            burst.bytes[4] = mb[1];
            burst.bytes[5] = mb[2];
        end
        else
        begin
            burst.bytes[0] = mb[0];
            burst.bytes[1] = mb[1];
            burst.bytes[2] = mb[2];
            burst.bytes[3] = mb[3];
        end
        burst.n_data     = nd;
        burst.tail_valid = fin || err;
        if (fin)
        begin
            burst.tail_kind   = KIND_FINISH;
            burst.tail_length = len32;
            burst.tail_header = (cnt_sat[LENGTH_BITS-1:7] == '0)
                              ? (8'h40 + {1'b0, cnt_sat[6:0]}) : 8'h0c;
        end
        else if (err)
        begin
            burst.tail_kind = KIND_ERROR;
            burst.tail_err  = err_code;
        end
    end

    // saturating decoded-byte count
    assign sum     = {1'b0, count_reg} + (LENGTH_BITS+1)'(nd);
    assign cnt_sat = sum[LENGTH_BITS] ? '1 : sum[LENGTH_BITS-1:0];

    generate
        if (LENGTH_BITS > 32)
        begin : g_len_wide
            assign len32 = (|cnt_sat[LENGTH_BITS-1:32]) ? 32'hffff_ffff
                                                       : cnt_sat[31:0];
        end
        else
        begin : g_len_narrow
            assign len32 = 32'(cnt_sat);
        end
    endgenerate

    always_comb
    begin
        count_next = cnt_sat;
        if (fin || err)
            count_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_NORMAL;
            acc_reg        <= '0;
            digits_reg     <= '0;
            follow_reg     <= '0;
            held_valid_reg <= 1'b0;
            held_reg       <= '0;
            count_reg      <= '0;
        end
        else if (take)
        begin
            if (fin || err)
            begin
                mode_reg       <= MODE_NORMAL;
                acc_reg        <= '0;
                digits_reg     <= '0;
                follow_reg     <= '0;
                held_valid_reg <= 1'b0;
                held_reg       <= '0;
            end
            else
            begin
                mode_reg       <= mode_next;
                acc_reg        <= acc_next;
                digits_reg     <= digits_next;
                follow_reg     <= follow_next;
                held_valid_reg <= held_valid_next;
                held_reg       <= held_next;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- sv/jsu_emit.sv -----
// Burst register and output register: hands out one result beat per cycle while res_stall is low.
module jsu_emit
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  burst_t    burst,
    output logic      busy,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res_beat
);

    burst_t     burst_reg;
    logic [2:0] idx_reg, idx_next;
    logic [2:0] rem_reg, rem_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;
    logic       out_load;

    assign out_load = (rem_reg != 3'd0) && (!out_valid_reg || !res_stall);
    // input held off while more than the final pending beat remains, or the final one cannot load yet
    assign busy     = (rem_reg > 3'd1) || (rem_reg == 3'd1 && !out_load);

    always_comb
    begin
        out_next             = '0;
        out_next.last_of_run = (rem_reg == 3'd1);
        if (idx_reg < burst_reg.n_data)
        begin
            out_next.kind      = KIND_DATA;
            out_next.data_byte = burst_reg.bytes[idx_reg];
        end
        else
        begin
            out_next.kind          = burst_reg.tail_kind;
            out_next.header_byte   = burst_reg.tail_header;
            out_next.string_length = burst_reg.tail_length;
            out_next.error_code    = burst_reg.tail_err;
        end

        idx_next = idx_reg;
        rem_next = rem_reg;
        if (take)
        begin
            idx_next = 3'd0;
            rem_next = burst.n_data + {2'b00, burst.tail_valid};
        end
        else if (out_load)
        begin
            idx_next = idx_reg + 3'd1;
            rem_next = rem_reg - 3'd1;
        end

        out_valid_next = out_load || (out_valid_reg && res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            burst_reg <= burst;
        if (out_load)
            out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res_beat  = out_reg;

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the JSON string unescaper: random and directed byte streams.
`timescale 1ns / 100ps

module tb_top;
    import jsu_pkg::*;

    localparam logic [7:0] QUOTE     = 8'h22;
    localparam logic [7:0] BACKSLASH = 8'h5c;
    localparam logic [7:0] SLASH     = 8'h2f;
    localparam int         CYCLE_LIMIT = 300000;

    // Decoder position inside the string body, as tracked by the predictor
    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_ESCAPE,
        MODE_HEX,
        MODE_UTF8
    } decode_mode_t;

    // Predicts the decoded stream and checks each result beat in order.
    class unescape_scoreboard;
        out_item_t    pending_results[$];
        out_item_t    beat_results[$];
        int unsigned  failures;
        decode_mode_t mode;
        logic [15:0]  hex_acc;
        logic [1:0]   hex_seen;
        logic [1:0]   follow_left;
        logic [15:0]  held;
        logic [31:0]  count;

        function new();
            failures = 0;
            clear_string();
        endfunction

        function void clear_string();
            mode        = MODE_TEXT;
            hex_acc     = '0;
            hex_seen    = '0;
            follow_left = '0;
            held        = '0;
            count       = '0;
        endfunction

        function void emit(logic [1:0] kind, logic [7:0] data, logic [7:0] hdr,
                           logic [31:0] len, logic [3:0] err);
            out_item_t r;
            r.kind          = kind;
            r.data_byte     = data;
            r.header_byte   = hdr;
            r.string_length = len;
            r.error_code    = err;
            r.last_of_run   = 1'b0;
            beat_results.push_back(r);
        endfunction

        // Decoded byte; the length counter sticks at all ones
        function void emit_byte(logic [7:0] b);
            if (count != '1)
                count++;
            emit(KIND_DATA, b, 8'h00, 32'd0, 4'd0);
        endfunction

        function void emit_three(logic [15:0] v);
            emit_byte(8'he0 + 8'(v[15:12]));
            emit_byte(8'h80 + 8'(v[11:6]));
            emit_byte(8'h80 + 8'(v[5:0]));
        endfunction

        function void flush_held();
            if (held != 0) begin
                emit_three(held);
                held = '0;
            end
        endfunction

        // Held surrogate bytes are dropped, never output
        function void fail(logic [3:0] code);
            clear_string();
            emit(KIND_ERROR, 8'h00, 8'h00, 32'd0, code);
        endfunction

        function void code_point(logic [15:0] v);
            logic [20:0] c;
            if (v < 16'h0080) begin
                flush_held();
                emit_byte(v[7:0]);
            end
            else if (v < 16'h0800) begin
                flush_held();
                emit_byte(8'hc0 + 8'(v[10:6]));
                emit_byte(8'h80 + 8'(v[5:0]));
            end
            else if (v >= 16'hdc00 && v < 16'he000 && held != 0) begin
                // surrogate pair joined into one 4-byte sequence
                c = 21'h10000 + (21'(held - 16'hd800) << 10) + 21'(v - 16'hdc00);
                held = '0;
                emit_byte(8'hf0 + 8'(c[20:18]));
                emit_byte(8'h80 + 8'(c[17:12]));
                emit_byte(8'h80 + 8'(c[11:6]));
                emit_byte(8'h80 + 8'(c[5:0]));
            end
            else begin
                flush_held();
                if (v >= 16'hd800 && v < 16'hdc00)
                    held = v;
                else
                    emit_three(v);
            end
        endfunction

        function void decode_byte(logic [7:0] b);
            logic [3:0]  nib;
            logic [7:0]  d;
            logic [15:0] v;
            logic [7:0]  hdr;
            logic [31:0] len;
            bit          ok;
            case (mode)
                MODE_UTF8: begin
                    if (b[7:6] != 2'b10)
                        fail(ERR_BAD_CONT);
                    else begin
                        emit_byte(b);
                        follow_left--;
                        if (follow_left == 0)
                            mode = MODE_TEXT;
                    end
                end
                MODE_HEX: begin
                    ok = 1'b1;
                    if (b >= "0" && b <= "9")
                        nib = 4'(b - "0");
                    else if (b >= "a" && b <= "f")
                        nib = 4'(b - "a" + 8'd10);
                    else if (b >= "A" && b <= "F")
                        nib = 4'(b - "A" + 8'd10);
                    else
                        ok = 1'b0;
                    if (!ok)
                        fail(ERR_BAD_HEX);
                    else begin
                        hex_acc = {hex_acc[11:0], nib};
                        if (hex_seen == 2'd3) begin
                            v        = hex_acc;
                            hex_seen = '0;
                            hex_acc  = '0;
                            mode     = MODE_TEXT;
                            code_point(v);
                        end
                        else
                            hex_seen++;
                    end
                end
                MODE_ESCAPE: begin
                    ok = 1'b1;
                    d  = b;
                    case (b)
                        QUOTE, SLASH, BACKSLASH: d = b;
                        "b": d = 8'h08;
                        "f": d = 8'h0c;
                        "n": d = 8'h0a;
                        "r": d = 8'h0d;
                        "t": d = 8'h09;
                        default: ok = 1'b0;
                    endcase
                    if (b == "u") begin
                        mode     = MODE_HEX;
                        hex_acc  = '0;
                        hex_seen = '0;
                    end
                    else if (!ok)
                        fail(ERR_BAD_ESCAPE);
                    else begin
                        mode = MODE_TEXT;
                        flush_held();
                        emit_byte(d);
                    end
                end
                default: begin
                    if (b == QUOTE) begin
                        flush_held();
                        len = count;
                        hdr = (len <= 32'd127) ? 8'h40 + len[7:0] : 8'h0c;
                        clear_string();
                        emit(KIND_FINISH, 8'h00, hdr, len, 4'd0);
                    end
                    else if (b == BACKSLASH)
                        mode = MODE_ESCAPE;
                    else if (!b[7]) begin
                        if (b < 8'h20)
                            fail(ERR_CONTROL);
                        else begin
                            flush_held();
                            emit_byte(b);
                        end
                    end
                    else if (b[7:6] == 2'b10)
                        fail(ERR_STRAY_CONT);
                    else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
                        if (b[7:5] == 3'b110)
                            follow_left = 2'd1;
                        else if (b[7:4] == 4'b1110)
                            follow_left = 2'd2;
                        else
                            follow_left = 2'd3;
                        mode = MODE_UTF8;
                        flush_held();
                        emit_byte(b);
                    end
                    else
                        fail(ERR_LONG_LEAD);
                end
            endcase
        endfunction

        // Called once per accepted input beat
        function void note_beat(in_item_t it);
            beat_results.delete();
            if (it.end_of_input) begin
                if (mode == MODE_HEX)
                    fail(ERR_UNFINISHED_HEX);
                else if (mode == MODE_UTF8)
                    fail(ERR_TRUNC_UTF8);
                else
                    fail(ERR_UNFINISHED);
            end
            else
                decode_byte(it.in_byte);
            if (beat_results.size() > 0)
                beat_results[$].last_of_run = 1'b1;
            foreach (beat_results[i])
                pending_results.push_back(beat_results[i]);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with none expected, actual kind %0h data %0h",
                         $time, got.kind, got.data_byte);
                failures++;
            end
            else begin
                want = pending_results.pop_front();
                compare_field("kind", 32'(want.kind), 32'(got.kind));
                compare_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
                compare_field("header_byte", 32'(want.header_byte), 32'(got.header_byte));
                compare_field("string_length", want.string_length, got.string_length);
                compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
                compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function int string_len();
            return int'(count);
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_beat;
    logic      res_valid;
    logic      res_stall;
    out_item_t res_beat;

    unescape_scoreboard sb = new();
    int  beats_sent = 0;
    int  cycles = 0;
    bit  calm = 1'b0;    // set for the closing stretch: no gaps, no stalls

    json_string_unescaper_unit #(
        .LENGTH_BITS(32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .byte_beat (byte_beat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hung handshake or a missing result ends here
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // All tb drives are nonblocking, so these reads see the values before the edge
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res_beat);
    end

    // Receiver back-pressure: random stall bursts between free-running stretches
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                res_stall <= 1'b0;
            end
            else
                repeat ($urandom_range(0, 24)) @(posedge clk);
        end
    end

    // One input beat: optional gap first, then hold it until taken.
    // The beat is logged with the predictor at the edge that accepts it.
    task automatic put_beat(in_item_t it);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_beat  <= it;
        do
            @(posedge clk);
        while (byte_stall);
        sb.note_beat(it);
        beats_sent++;
    endtask

    task automatic put_byte(logic [7:0] b);
        in_item_t it;
        it.in_byte      = b;
        it.end_of_input = 1'b0;
        put_beat(it);
    endtask

    // End of input; the byte lane carries junk that must be ignored
    task automatic put_eoi();
        in_item_t it;
        it.in_byte      = 8'($urandom_range(0, 255));
        it.end_of_input = 1'b1;
        put_beat(it);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10)
            return 8'h30 + 8'(nib);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    task automatic send_u(logic [15:0] v);
        put_byte(BACKSLASH);
        put_byte("u");
        for (int i = 3; i >= 0; i--)
            put_byte(hex_char(v[i*4 +: 4]));
    endtask

    task automatic send_ascii();
        logic [7:0] b;
        b = 8'($urandom_range(8'h20, 8'h7f));
        if (b == QUOTE || b == BACKSLASH)
            b = 8'h7f;
        put_byte(b);
    endtask

    // Broken or junk input: bad bytes, early end, cut-off escapes and sequences
    task automatic send_noise();
        int n;
        case ($urandom_range(0, 4))
            0: put_byte(8'($urandom_range(0, 255)));
            1: put_eoi();
            2:
            begin
                put_byte(BACKSLASH);
                put_byte(8'($urandom_range(0, 255)));
            end
            3:
            begin
                put_byte(BACKSLASH);
                put_byte("u");
                n = $urandom_range(0, 3);
                repeat (n) put_byte(hex_char(4'($urandom_range(0, 15))));
                if ($urandom_range(0, 1))
                    put_eoi();
                else
                    put_byte(8'($urandom_range(0, 255)));
            end
            default:
            begin
                put_byte(8'($urandom_range(8'hc0, 8'hf7)));
                n = $urandom_range(0, 2);
                repeat (n) put_byte(8'h80 | 8'($urandom_range(0, 63)));
                if ($urandom_range(0, 1))
                    put_eoi();
                else
                    put_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // One element of a string body, mostly well formed; clean leaves out the noise
    task automatic send_element(bit clean);
        logic [7:0] esc_chars [8] = '{QUOTE, SLASH, BACKSLASH, "b", "f", "n", "r", "t"};
        int r;
        int n;
        r = $urandom_range(0, clean ? 91 : 99);
        if (r < 30)
            send_ascii();
        else if (r < 42)
        begin
            put_byte(BACKSLASH);
            put_byte(esc_chars[$urandom_range(0, 7)]);
        end
        else if (r < 62)
        begin
            case ($urandom_range(0, 4))
                0: send_u(16'($urandom_range(16'h0000, 16'h007f)));
                1: send_u(16'($urandom_range(16'h0080, 16'h07ff)));
                2: send_u(16'($urandom_range(16'h0800, 16'hffff)));
                3: send_u(16'($urandom_range(16'hd800, 16'hdbff)));   // lone high surrogate
                default: send_u(16'($urandom_range(16'hdc00, 16'hdfff)));  // lone low
            endcase
        end
        else if (r < 80)
        begin
            // raw UTF-8: lead then 1..3 continuation bytes
            n = $urandom_range(2, 4);
            case (n)
                2: put_byte(8'hc0 | 8'($urandom_range(0, 31)));
                3: put_byte(8'he0 | 8'($urandom_range(0, 15)));
                default: put_byte(8'hf0 | 8'($urandom_range(0, 7)));
            endcase
            repeat (n - 1) put_byte(8'h80 | 8'($urandom_range(0, 63)));
        end
        else if (r < 92)
        begin
            // surrogate pair, joined into one 4-byte code point
            send_u(16'($urandom_range(16'hd800, 16'hdbff)));
            send_u(16'($urandom_range(16'hdc00, 16'hdfff)));
        end
        else
            send_noise();
    endtask

    task automatic send_string(int elements);
        repeat (elements) send_element(1'b0);
        put_byte(QUOTE);
    endtask

    initial
    begin
        int target;
        byte_valid <= 1'b0;
        byte_beat  <= '0;
        res_stall  <= 1'b0;
        rst_n      <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes and the awkward corners
        put_byte(8'h00);                 // control character
        put_byte(8'hff);                 // lead byte with five leading ones
        put_byte(BACKSLASH);             // end straight after a backslash
        put_eoi();
        send_u(16'hd800);                // held high surrogate flushed by the quote
        put_byte(QUOTE);
        put_byte(8'he2);                 // quote inside a UTF-8 sequence
        put_byte(QUOTE);
        put_byte(8'hc3);                 // end inside a UTF-8 sequence
        put_eoi();
        put_byte(BACKSLASH);             // end inside a \u escape
        put_byte("u");
        put_byte("1");
        put_eoi();
        put_byte(8'h80);                 // stray continuation
        put_byte(QUOTE);                 // empty string

        // Random strings, mostly well formed with noise mixed in
        while (beats_sent < 30)
            send_string($urandom_range(0, 6));

        // One long string landing on 127 or 128 bytes: short/long header boundary.
        // Mostly plain text so that it stays short in beats.
        target = $urandom_range(127, 128);
        while (sb.string_len() < target)
        begin
            if (target - sb.string_len() < 8 || $urandom_range(0, 9) != 0)
                send_ascii();
            else
                send_element(1'b1);
        end
        put_byte(QUOTE);

        // Closing stretch with no gaps and no stalls
        calm = 1'b1;
        repeat (2) send_string($urandom_range(1, 6));
        byte_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
